>>> rtl/core/e2rm_pkg.sv
package e2rm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int CORDIC_STEPS   = 30;
  localparam int ENTRY_W        = 16;
  localparam int WORK_W         = 34;
  localparam logic signed [WORK_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] WHICH_ROT = 2'd0;
  localparam logic [1:0] WHICH_DA  = 2'd1;
  localparam logic [1:0] WHICH_DB  = 2'd2;
  localparam logic [1:0] WHICH_DG  = 2'd3;

  // Arctangent table in units of 2^-32 turn.
  function automatic logic signed [WORK_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [WORK_W-1:0] r;
    r = '0;
    unique case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/euler_to_rotation_matrix_3d_top.sv
// Channel | Signals                                        | Direction
// request | valid_i, stall_o, opcode_i, alpha_i..gamma_i   | in
// result  | valid_o, stall_i, m00_o..m22_o, which_matrix_o, | out
//         | last_o                                         |
// A request is registered, passes 30 CORDIC stages (one step each), a sine and
// cosine stage and two product stages, and its sums load an output buffer that
// holds one request's matrices. A rotation request gives one result, a
// derivative request three; the buffer's single output port sets the rate at
// one result per cycle while stall_i is low; a derivative request holds the
// pipeline until its three results are taken. Reset clears all valid bits;
// the pipeline advances only when its end can drain, so stalls lose and
// repeat nothing.
module euler_to_rotation_matrix_3d_top #(
  parameter int ANGLE_BITS = e2rm_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = e2rm_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic                  opcode_i,
  input  logic [ANGLE_BITS-1:0] alpha_i,
  input  logic [ANGLE_BITS-1:0] beta_i,
  input  logic [ANGLE_BITS-1:0] gamma_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic signed [15:0]    m00_o,
  output logic signed [15:0]    m01_o,
  output logic signed [15:0]    m02_o,
  output logic signed [15:0]    m10_o,
  output logic signed [15:0]    m11_o,
  output logic signed [15:0]    m12_o,
  output logic signed [15:0]    m20_o,
  output logic signed [15:0]    m21_o,
  output logic signed [15:0]    m22_o,
  output logic [1:0]            which_matrix_o,
  output logic                  last_o
);
  import e2rm_pkg::*;

  localparam int NS = CORDIC_STEPS;
  localparam int FW = FRAC_BITS + 2;       // signed value width for +-2^F
  localparam int PW = 2 * FW;              // product width
  localparam int SH = 30 - FRAC_BITS;      // CORDIC Q.30 to Q.F shift
  localparam logic signed [FW-1:0] ONE  = FW'(1) <<< FRAC_BITS;
  localparam logic signed [FW-1:0] MONE = -(FW'(1) <<< FRAC_BITS);

  typedef logic signed [FW-1:0] val_t;
  typedef logic signed [WORK_W-1:0] wrk_t;

  // Pipeline advance: the whole pipe moves when the output buffer can take.
  logic adv;
  logic buf_free;

  // ---------------- CORDIC pipeline (three angles in lanes) ----------------
  wrk_t       cx_q [3][NS+1];
  wrk_t       cy_q [3][NS+1];
  wrk_t       cz_q [3][NS+1];
  logic [1:0] cq_q [3][NS+1];
  logic       cv_q [NS+1];
  logic       cop_q[NS+1];
  logic [31:0] ph [3];

  assign ph[0] = 32'(alpha_i) << (32 - ANGLE_BITS);
  assign ph[1] = 32'(beta_i)  << (32 - ANGLE_BITS);
  assign ph[2] = 32'(gamma_i) << (32 - ANGLE_BITS);

  // Stage 0 latches the request; stage s+1 applies CORDIC step s.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) cv_q[s] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= valid_i;
      for (int s = 0; s < NS; s++) cv_q[s+1] <= cv_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cop_q[0] <= opcode_i;
      for (int s = 0; s < NS; s++) cop_q[s+1] <= cop_q[s];
      for (int l = 0; l < 3; l++) begin
        cx_q[l][0] <= CORDIC_GAIN;
        cy_q[l][0] <= '0;
        cz_q[l][0] <= WORK_W'({2'b00, ph[l][29:0]});
        cq_q[l][0] <= ph[l][31:30];
        for (int s = 0; s < NS; s++) begin
          cq_q[l][s+1] <= cq_q[l][s];
          if (!cz_q[l][s][WORK_W-1]) begin
            cx_q[l][s+1] <= cx_q[l][s] - (cy_q[l][s] >>> s);
            cy_q[l][s+1] <= cy_q[l][s] + (cx_q[l][s] >>> s);
            cz_q[l][s+1] <= cz_q[l][s] - atan_lut(5'(s));
          end else begin
            cx_q[l][s+1] <= cx_q[l][s] + (cy_q[l][s] >>> s);
            cy_q[l][s+1] <= cy_q[l][s] - (cx_q[l][s] >>> s);
            cz_q[l][s+1] <= cz_q[l][s] + atan_lut(5'(s));
          end
        end
      end
    end
  end

  // Round to FRAC_BITS, clamp, apply quadrant.
  function automatic val_t to_frac(input wrk_t v);
    wrk_t r;
    r = v;
    if (SH > 0) r = (v + (wrk_t'(1) <<< (SH - 1))) >>> SH;
    if (r < 0) r = '0;
    if (r > wrk_t'(ONE)) r = wrk_t'(ONE);
    return FW'(r);
  endfunction

  val_t sn [3];
  val_t cs [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      val_t fx, fy;
      fx = to_frac(cx_q[l][NS]);
      fy = to_frac(cy_q[l][NS]);
      unique case (cq_q[l][NS])
        2'd0: begin sn[l] = fy;  cs[l] = fx;  end
        2'd1: begin sn[l] = fx;  cs[l] = -fy; end
        2'd2: begin sn[l] = -fy; cs[l] = -fx; end
        default: begin sn[l] = -fx; cs[l] = fy; end
      endcase
    end
  end

  function automatic val_t fmul(input val_t a, input val_t b);
    logic signed [PW-1:0] r;
    r = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC_BITS - 1));
    return FW'(r >>> FRAC_BITS);
  endfunction

  function automatic val_t fsat(input logic signed [FW:0] v);
    if (v > (FW+1)'(ONE)) return ONE;
    if (v < (FW+1)'(MONE)) return MONE;
    return FW'(v);
  endfunction

  function automatic logic signed [FW:0] wid(input val_t v);
    return (FW+1)'(v);
  endfunction

  // Stage A: sines/cosines registered (a=0, b=1, g=2).
  val_t sa_q, ca_q, sb_q, cb_q, sg_q, cg_q;
  logic va_q, opa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= cv_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      opa_q <= cop_q[NS];
      sa_q <= sn[0]; ca_q <= cs[0];
      sb_q <= sn[1]; cb_q <= cs[1];
      sg_q <= sn[2]; cg_q <= cs[2];
    end
  end

  // Stage B: first-level products.
  val_t cgcb_q, sgcb_q, cgsb_q, sgsb_q, sgsa_q, cgsa_q, sgca_q, cgca_q;
  val_t sbca_q, sbsa_q, cbca_q, cbsa_q;
  val_t bsa_q, bca_q, bcb_q, bsb_q;
  logic vb_q, opb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (adv) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      opb_q  <= opa_q;
      cgcb_q <= fmul(cg_q, cb_q); sgcb_q <= fmul(sg_q, cb_q);
      cgsb_q <= fmul(cg_q, sb_q); sgsb_q <= fmul(sg_q, sb_q);
      sgsa_q <= fmul(sg_q, sa_q); cgsa_q <= fmul(cg_q, sa_q);
      sgca_q <= fmul(sg_q, ca_q); cgca_q <= fmul(cg_q, ca_q);
      sbca_q <= fmul(sb_q, ca_q); sbsa_q <= fmul(sb_q, sa_q);
      cbca_q <= fmul(cb_q, ca_q); cbsa_q <= fmul(cb_q, sa_q);
      bsa_q <= sa_q; bca_q <= ca_q; bcb_q <= cb_q; bsb_q <= sb_q;
    end
  end

  // Stage C: second-level products, pass-throughs.
  val_t p_q, q_q, r_q, s_q, t0_q, t1_q, t2_q, t3_q;
  val_t c_sgsa_q, c_cgsa_q, c_sgca_q, c_cgca_q, c_sbca_q, c_sbsa_q;
  val_t c_cbca_q, c_cbsa_q, c_cgsb_q, c_sgsb_q, c_cgcb_q, c_sgcb_q, c_cb_q, c_sb_q;
  logic vc_q, opc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (adv) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      opc_q <= opb_q;
      p_q  <= fmul(cgcb_q, bca_q); q_q  <= fmul(sgcb_q, bca_q);
      r_q  <= fmul(cgcb_q, bsa_q); s_q  <= fmul(sgcb_q, bsa_q);
      t0_q <= fmul(cgsb_q, bca_q); t1_q <= fmul(sgsb_q, bca_q);
      t2_q <= fmul(cgsb_q, bsa_q); t3_q <= fmul(sgsb_q, bsa_q);
      c_sgsa_q <= sgsa_q; c_cgsa_q <= cgsa_q; c_sgca_q <= sgca_q; c_cgca_q <= cgca_q;
      c_sbca_q <= sbca_q; c_sbsa_q <= sbsa_q; c_cbca_q <= cbca_q; c_cbsa_q <= cbsa_q;
      c_cgsb_q <= cgsb_q; c_sgsb_q <= sgsb_q; c_cgcb_q <= cgcb_q; c_sgcb_q <= sgcb_q;
      c_cb_q <= bcb_q; c_sb_q <= bsb_q;
    end
  end

  // Stage D: saturated sums into rotation and d/dbeta matrices.
  val_t rot_d [9];
  val_t db_d  [9];
  always_comb begin
    rot_d[0] = fsat(wid(p_q) - wid(c_sgsa_q));
    rot_d[1] = fsat(-wid(q_q) - wid(c_cgsa_q));
    rot_d[2] = fsat(wid(c_sbca_q));
    rot_d[3] = fsat(wid(r_q) + wid(c_sgca_q));
    rot_d[4] = fsat(-wid(s_q) + wid(c_cgca_q));
    rot_d[5] = fsat(wid(c_sbsa_q));
    rot_d[6] = fsat(-wid(c_cgsb_q));
    rot_d[7] = fsat(wid(c_sgsb_q));
    rot_d[8] = fsat(wid(c_cb_q));
    db_d[0]  = fsat(-wid(t0_q));
    db_d[1]  = fsat(wid(t1_q));
    db_d[2]  = fsat(wid(c_cbca_q));
    db_d[3]  = fsat(-wid(t2_q));
    db_d[4]  = fsat(wid(t3_q));
    db_d[5]  = fsat(wid(c_cbsa_q));
    db_d[6]  = fsat(-wid(c_cgcb_q));
    db_d[7]  = fsat(wid(c_sgcb_q));
    db_d[8]  = fsat(-wid(c_sb_q));
  end

  // Output buffer: holds one request's matrices and emits them in turn.
  val_t rot_q [9];
  val_t db_q  [9];
  logic       bop_q;
  logic       bv_q;
  logic [1:0] idx_q;
  logic       fire;

  assign fire     = bv_q && !stall_i;
  assign buf_free = !bv_q || (fire && (!bop_q || idx_q == WHICH_DG));
  assign adv      = buf_free;
  assign stall_o  = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q  <= 1'b0;
      idx_q <= WHICH_ROT;
    end else if (adv) begin
      bv_q  <= vc_q;
      idx_q <= opc_q ? WHICH_DA : WHICH_ROT;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bop_q <= opc_q;
      for (int k = 0; k < 9; k++) begin
        rot_q[k] <= rot_d[k];
        db_q[k]  <= db_d[k];
      end
    end
  end

  val_t om [9];
  always_comb begin
    unique case (idx_q)
      WHICH_ROT: for (int k = 0; k < 9; k++) om[k] = rot_q[k];
      WHICH_DA: begin
        for (int j = 0; j < 3; j++) begin
          om[j]   = -rot_q[3+j];
          om[3+j] = rot_q[j];
          om[6+j] = '0;
        end
      end
      WHICH_DB: for (int k = 0; k < 9; k++) om[k] = db_q[k];
      default: begin
        om[0] = rot_q[1]; om[1] = -rot_q[0]; om[2] = '0;
        om[3] = rot_q[4]; om[4] = -rot_q[3]; om[5] = '0;
        om[6] = rot_q[7]; om[7] = -rot_q[6]; om[8] = '0;
      end
    endcase
  end

  function automatic logic signed [15:0] ent(input val_t v);
    logic signed [FW+15:0] e;
    e = (FW+16)'(v);
    return e[15:0];
  endfunction

  assign valid_o        = bv_q;
  assign m00_o          = ent(om[0]);
  assign m01_o          = ent(om[1]);
  assign m02_o          = ent(om[2]);
  assign m10_o          = ent(om[3]);
  assign m11_o          = ent(om[4]);
  assign m12_o          = ent(om[5]);
  assign m20_o          = ent(om[6]);
  assign m21_o          = ent(om[7]);
  assign m22_o          = ent(om[8]);
  assign which_matrix_o = idx_q;
  assign last_o         = !bop_q || (idx_q == WHICH_DG);

  // A rotation result is always last; a derivative sequence starts at d/dalpha.
  a_rot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && which_matrix_o == WHICH_ROT) |-> last_o)
    else $error("rotation result not flagged last");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && bop_q && idx_q != WHICH_DG) |=> (valid_o && idx_q == $past(idx_q) + 2'd1))
    else $error("derivative sequence broken");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(which_matrix_o)))
    else $error("stalled result changed");

endmodule
